>>> hw/rtl/pgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_pkg
// Shared types and fixed constants for the polar Gaussian transform.
// ----------------------------------------------------------------------------
package pgt_pkg;

  // Field widths of the transfers
  localparam int unsigned FIELD_W  = 31;
  localparam int unsigned SAMPLE_W = 32;

  typedef struct packed {
    logic [FIELD_W-1:0] first_draw;
    logic [FIELD_W-1:0] second_draw;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } out_t;

  // Log unit: Q1.30 mantissa, one fraction bit per squaring round
  localparam int unsigned MANT_W     = 31;
  localparam int unsigned LOG_ROUNDS = 30;

  // 2*ln(2) in Q.30
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

  // Square root unit: 64-bit radicand, one root bit per stage
  localparam int unsigned RAD_W  = 64;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned REM_W  = 35;

  // Divider: quotient bits, one per stage
  localparam int unsigned QUO_W = 31;

  // The radicand of the norm root is placed with its top bit at 60 or 61
  localparam int unsigned NORM_TOP = 61;

endpackage

>>> hw/rtl/polar_gaussian_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_gaussian_transform
// Polar-method Gaussian generator: each pair of uniform draws gives two
// normal samples in Q5.27, or none when it is off the disc or at its centre.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one pair of
//   draws per transfer. Output channel (out_valid_o / out_stall_i /
//   out_data_o) gives the sample from the second draw first, then the one
//   from the first draw with last set. A rejected pair gives no transfer.
//   The second sample follows in the next cycle when the receiver does not
//   stall. Throughput: the pipeline takes a pair every cycle unless it is
//   stalled; the single-sample output port holds the pipeline while it sends
//   the first sample of a pair, and rejected pairs take no output slot.
//   Pipeline: 5 front stages (magnitudes, squares, norm, top bit, normalise),
//   then two 63-stage branches side by side (log, scale, root of the log;
//   root of the norm, two dividers), one product stage and the output stage.
//   Reset clears all valid bits and the output phase flag; no sweep needed.
//   A stall on the output freezes the whole pipeline and raises in_stall_o
//   while a held pair cannot move on; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module polar_gaussian_transform #(
  parameter int unsigned DRAW_BITS = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pgt_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pgt_pkg::out_t    out_data_o
);

  localparam int unsigned FRAC_BITS = DRAW_BITS - 1;
  localparam int unsigned MAG_W     = DRAW_BITS;
  localparam int unsigned RSQ_W     = 2 * MAG_W;
  localparam int unsigned K_W       = $clog2(RSQ_W);
  localparam int unsigned NUM_W     = MAG_W + 61;
  localparam int unsigned QW        = pgt_pkg::QUO_W;
  localparam int unsigned MW        = pgt_pkg::MANT_W;
  localparam int unsigned LR        = pgt_pkg::LOG_ROUNDS;
  localparam int unsigned SW        = pgt_pkg::SAMPLE_W;
  localparam int unsigned PROD_W    = QW + pgt_pkg::ROOT_W;
  localparam int unsigned MAGS_W    = PROD_W - 28;

  logic adv;

  // --------------------------------------------------------------------------
  // Stage 0: draws to magnitude and sign
  // --------------------------------------------------------------------------
  logic [DRAW_BITS-1:0] d1, d2;
  logic [MAG_W-1:0]     half;
  logic [MAG_W-1:0]     mag1_d, mag2_d;

  assign d1   = DRAW_BITS'(in_data_i.first_draw);
  assign d2   = DRAW_BITS'(in_data_i.second_draw);
  assign half = MAG_W'(1) << FRAC_BITS;
  assign mag1_d = (d1 >= half) ? (d1 - half) : (half - d1);
  assign mag2_d = (d2 >= half) ? (d2 - half) : (half - d2);

  logic             v0_q, v1_q, v2_q, v3_q, v4_q;
  logic [MAG_W-1:0] mag1_0q, mag2_0q, mag1_1q, mag2_1q, mag1_2q, mag2_2q;
  logic [MAG_W-1:0] mag1_3q, mag2_3q;
  logic [1:0]       neg_0q, neg_1q, neg_2q, neg_3q, neg_4q;
  logic [RSQ_W-1:0] sq1_1q, sq2_1q, rsq_2q, rsq_3q;
  logic [K_W-1:0]   k_3q, k_4q;

  // --------------------------------------------------------------------------
  // Stages 2 to 4: norm, reject test, top bit, normalise
  // --------------------------------------------------------------------------
  logic [RSQ_W-1:0] rsq_d;
  logic             ok_d;
  logic [K_W-1:0]   k_d;

  assign rsq_d = sq1_1q + sq2_1q;
  assign ok_d  = (rsq_d != '0) && (rsq_d < (RSQ_W'(1) << (2 * FRAC_BITS)));

  always_comb begin
    k_d = '0;
    for (int i = 0; i < RSQ_W; i++) begin
      if (rsq_2q[i]) k_d = K_W'(i);
    end
  end

  logic [MW-1:0]            mant_d;
  logic [6:0]               e_d;
  logic [6:0]               sh_d;
  logic [pgt_pkg::RAD_W-1:0] radq_d;
  logic [NUM_W-1:0]         num1_d, num2_d;

  assign mant_d = MW'({rsq_3q, 30'b0} >> k_3q);
  assign e_d    = (7'(pgt_pkg::NORM_TOP) - 7'(k_3q)) & ~7'd1;
  assign sh_d   = (e_d >> 1) + 7'd30;
  assign radq_d = pgt_pkg::RAD_W'(rsq_3q) << e_d;
  assign num1_d = NUM_W'(mag1_3q) << sh_d;
  assign num2_d = NUM_W'(mag2_3q) << sh_d;

  logic [MW-1:0]             mant_4q;
  logic [pgt_pkg::RAD_W-1:0] radq_4q;
  logic [4*QW-1:0]           nums_4q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q & ok_d;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag1_0q <= mag1_d;
      mag2_0q <= mag2_d;
      neg_0q  <= {d1 < half, d2 < half};
      sq1_1q  <= RSQ_W'(mag1_0q) * RSQ_W'(mag1_0q);
      sq2_1q  <= RSQ_W'(mag2_0q) * RSQ_W'(mag2_0q);
      mag1_1q <= mag1_0q;
      mag2_1q <= mag2_0q;
      neg_1q  <= neg_0q;
      rsq_2q  <= rsq_d;
      mag1_2q <= mag1_1q;
      mag2_2q <= mag2_1q;
      neg_2q  <= neg_1q;
      rsq_3q  <= rsq_2q;
      k_3q    <= k_d;
      mag1_3q <= mag1_2q;
      mag2_3q <= mag2_2q;
      neg_3q  <= neg_2q;
      mant_4q <= mant_d;
      radq_4q <= radq_d;
      nums_4q <= {num1_d[QW +: QW], num1_d[QW-1:0], num2_d[QW +: QW], num2_d[QW-1:0]};
      k_4q    <= k_3q;
      neg_4q  <= neg_3q;
    end
  end

  // --------------------------------------------------------------------------
  // Branch A: log2 fraction, scale to -2 ln(r^2), square root
  // --------------------------------------------------------------------------
  logic              va_log;
  logic [LR-1:0]     frac_a;
  logic [K_W+1:0]    side_a;

  pgt_log #(.SIDE_W(K_W + 2)) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .mant_i  (mant_4q),
    .side_i  ({k_4q, neg_4q}),
    .valid_o (va_log),
    .frac_o  (frac_a),
    .side_o  (side_a)
  );

  logic [6:0]  th;
  logic [36:0] t_full;
  logic [37:0] hi_prod;
  logic [60:0] lo_prod;
  logic [37:0] l_d;

  assign th      = 7'(2 * FRAC_BITS) - 7'(side_a[K_W+1:2]);
  assign t_full  = {th, 30'b0} - 37'(frac_a);
  assign hi_prod = 38'(t_full[36:30]) * 38'(pgt_pkg::TWO_LN2_Q30);
  assign lo_prod = 61'(t_full[29:0]) * 61'(pgt_pkg::TWO_LN2_Q30);
  assign l_d     = hi_prod + 38'(lo_prod[60:30]);

  logic        vl_q;
  logic [37:0] l_q;
  logic [1:0]  negl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= 1'b0;
    end else if (adv) begin
      vl_q <= va_log;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_q    <= l_d;
      negl_q <= side_a[1:0];
    end
  end

  logic                        va;
  logic [pgt_pkg::ROOT_W-1:0]  s_root;
  logic [1:0]                  neg_a;

  pgt_isqrt #(.SIDE_W(2)) u_sqrt_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vl_q),
    .rad_i   (pgt_pkg::RAD_W'(l_q) << 20),
    .side_i  (negl_q),
    .valid_o (va),
    .root_o  (s_root),
    .side_o  (neg_a)
  );

  // --------------------------------------------------------------------------
  // Branch B: root of the norm, then |v| / root for both lanes
  // --------------------------------------------------------------------------
  logic                        vq;
  logic [pgt_pkg::ROOT_W-1:0]  q_root;
  logic [4*QW-1:0]             nums_b;

  pgt_isqrt #(.SIDE_W(4 * QW)) u_sqrt_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .rad_i   (radq_4q),
    .side_i  (nums_4q),
    .valid_o (vq),
    .root_o  (q_root),
    .side_o  (nums_b)
  );

  logic          vb1, vb2;
  logic [QW-1:0] r1, r2;

  pgt_div u_div_first (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (vq),
    .num_hi_i (nums_b[3*QW +: QW]),
    .num_lo_i (nums_b[2*QW +: QW]),
    .den_i    (q_root[QW-1:0]),
    .valid_o  (vb1),
    .quo_o    (r1)
  );

  pgt_div u_div_second (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (vq),
    .num_hi_i (nums_b[QW +: QW]),
    .num_lo_i (nums_b[0 +: QW]),
    .den_i    (q_root[QW-1:0]),
    .valid_o  (vb2),
    .quo_o    (r2)
  );

  // --------------------------------------------------------------------------
  // Product stage: |sample| = R * S / 2^28
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] p1, p2;
  logic              v5_q;
  logic [MAGS_W-1:0] m1_q, m2_q;
  logic [1:0]        neg5_q;

  assign p1 = PROD_W'(r1) * PROD_W'(s_root);
  assign p2 = PROD_W'(r2) * PROD_W'(s_root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= va & vb1 & vb2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q   <= p1[PROD_W-1:28];
      m2_q   <= p2[PROD_W-1:28];
      neg5_q <= neg_a;
    end
  end

  // saturate the magnitude and apply the sign
  function automatic logic [SW-1:0] to_sample(input logic [MAGS_W-1:0] m, input logic neg);
    logic [MAGS_W-1:0] lim;
    logic [MAGS_W-1:0] c;
    lim = neg ? (MAGS_W'(1) << (SW - 1)) : ((MAGS_W'(1) << (SW - 1)) - MAGS_W'(1));
    c   = (m > lim) ? lim : m;
    to_sample = neg ? (SW'(0) - c[SW-1:0]) : c[SW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Output stage: holds one pair, sends second-draw sample first
  // --------------------------------------------------------------------------
  logic          out_valid_q, phase_q;
  logic [SW-1:0] smp_first_q, smp_last_q;

  assign adv        = !out_valid_q || (phase_q && !out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v5_q;
      phase_q     <= 1'b0;
    end else if (!out_stall_i) begin
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v5_q) begin
      smp_first_q <= to_sample(m2_q, neg5_q[0]);
      smp_last_q  <= to_sample(m1_q, neg5_q[1]);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o.sample = phase_q ? smp_last_q : smp_first_q;
  assign out_data_o.last   = phase_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_branch_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va == vb1) && (vb1 == vb2))
    else $error("pipeline branches out of step");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output stage");

  a_pair_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last) |=> (out_valid_o && out_data_o.last))
    else $error("second sample of a pair missing");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("output changed under stall");

endmodule

>>> hw/rtl/pgt_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_log
// Pipelined base-2 logarithm fraction: one squaring round per stage.
// ----------------------------------------------------------------------------
module pgt_log #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [pgt_pkg::MANT_W-1:0]           mant_i,
  input  logic [SIDE_W-1:0]                    side_i,
  output logic                                 valid_o,
  output logic [pgt_pkg::LOG_ROUNDS-1:0]       frac_o,
  output logic [SIDE_W-1:0]                    side_o
);

  localparam int unsigned N  = pgt_pkg::LOG_ROUNDS;
  localparam int unsigned MW = pgt_pkg::MANT_W;

  logic [N-1:0]    valid_q;
  logic [MW-1:0]   mant_q [N];
  logic [N-1:0]    frac_q [N];
  logic [SIDE_W-1:0] side_q [N];

  for (genvar j = 0; j < N; j++) begin : g_round
    logic            v_in;
    logic [MW-1:0]   m_in;
    logic [N-1:0]    f_in;
    logic [SIDE_W-1:0] s_in;
    logic [2*MW-1:0] sq;
    logic [MW:0]     p;
    logic [MW-1:0]   mant_d;
    logic [N-1:0]    frac_d;

    if (j == 0) begin : g_head
      assign v_in = valid_i;
      assign m_in = mant_i;
      assign f_in = '0;
      assign s_in = side_i;
    end else begin : g_tail
      assign v_in = valid_q[j-1];
      assign m_in = mant_q[j-1];
      assign f_in = frac_q[j-1];
      assign s_in = side_q[j-1];
    end

    // square and renormalise; a carry into bit 31 yields a fraction bit
    assign sq = (2*MW)'(m_in) * (2*MW)'(m_in);
    assign p  = sq[2*MW-1:MW-1];

    always_comb begin
      frac_d = f_in;
      mant_d = p[MW-1:0];
      if (p[MW]) begin
        frac_d[N-1-j] = 1'b1;
        mant_d        = p[MW:1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mant_q[j] <= mant_d;
        frac_q[j] <= frac_d;
        side_q[j] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign frac_o  = frac_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

>>> hw/rtl/pgt_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_isqrt
// Pipelined integer square root, restoring method, one root bit per stage.
// ----------------------------------------------------------------------------
module pgt_isqrt #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [pgt_pkg::RAD_W-1:0]        rad_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic [pgt_pkg::ROOT_W-1:0]       root_o,
  output logic [SIDE_W-1:0]                side_o
);

  localparam int unsigned N  = pgt_pkg::ROOT_W;
  localparam int unsigned AW = pgt_pkg::RAD_W;
  localparam int unsigned RW = pgt_pkg::REM_W;

  logic [N-1:0]      valid_q;
  logic [AW-1:0]     rad_q  [N];
  logic [RW-1:0]     rem_q  [N];
  logic [N-1:0]      root_q [N];
  logic [SIDE_W-1:0] side_q [N];

  for (genvar j = 0; j < N; j++) begin : g_digit
    logic              v_in;
    logic [AW-1:0]     a_in;
    logic [RW-1:0]     r_in;
    logic [N-1:0]      q_in;
    logic [SIDE_W-1:0] s_in;
    logic [RW-1:0]     rem2;
    logic [RW-1:0]     trial;
    logic [RW-1:0]     rem_d;
    logic [N-1:0]      root_d;

    if (j == 0) begin : g_head
      assign v_in = valid_i;
      assign a_in = rad_i;
      assign r_in = '0;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_tail
      assign v_in = valid_q[j-1];
      assign a_in = rad_q[j-1];
      assign r_in = rem_q[j-1];
      assign q_in = root_q[j-1];
      assign s_in = side_q[j-1];
    end

    // bring down two radicand bits, try 4*root + 1
    assign rem2  = {r_in[RW-3:0], a_in[AW-1:AW-2]};
    assign trial = RW'({q_in, 2'b01});

    always_comb begin
      if (rem2 >= trial) begin
        rem_d  = rem2 - trial;
        root_d = {q_in[N-2:0], 1'b1};
      end else begin
        rem_d  = rem2;
        root_d = {q_in[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j]  <= {a_in[AW-3:0], 2'b00};
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
        side_q[j] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

>>> hw/rtl/pgt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees that the upper dividend part is below the divisor.
// ----------------------------------------------------------------------------
module pgt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [pgt_pkg::QUO_W-1:0]     num_hi_i,
  input  logic [pgt_pkg::QUO_W-1:0]     num_lo_i,
  input  logic [pgt_pkg::QUO_W-1:0]     den_i,
  output logic                          valid_o,
  output logic [pgt_pkg::QUO_W-1:0]     quo_o
);

  localparam int unsigned N = pgt_pkg::QUO_W;

  logic [N-1:0] valid_q;
  logic [N-1:0] rem_q [N];
  logic [N-1:0] lo_q  [N];
  logic [N-1:0] den_q [N];
  logic [N-1:0] quo_q [N];

  for (genvar j = 0; j < N; j++) begin : g_bit
    logic         v_in;
    logic [N-1:0] r_in;
    logic [N-1:0] l_in;
    logic [N-1:0] d_in;
    logic [N-1:0] q_in;
    logic [N:0]   r2;
    logic [N:0]   diff;
    logic         take;

    if (j == 0) begin : g_head
      assign v_in = valid_i;
      assign r_in = num_hi_i;
      assign l_in = num_lo_i;
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_tail
      assign v_in = valid_q[j-1];
      assign r_in = rem_q[j-1];
      assign l_in = lo_q[j-1];
      assign d_in = den_q[j-1];
      assign q_in = quo_q[j-1];
    end

    // shift in the next dividend bit and subtract where it fits
    assign r2   = {r_in, l_in[N-1]};
    assign diff = r2 - {1'b0, d_in};
    assign take = (r2 >= {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? diff[N-1:0] : r2[N-1:0];
        lo_q[j]  <= {l_in[N-2:0], 1'b0};
        den_q[j] <= d_in;
        quo_q[j] <= {q_in[N-2:0], take};
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign quo_o   = quo_q[N-1];

endmodule
